// File: rtl/core/assert_macros.svh
// Assertion macros shared by the checker module of the icon pixel expander.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MIPE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mipe check failed (same cycle)");

// Next-cycle implication, checked outside reset.
`define MIPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mipe check failed (next cycle)");

`endif

// File: rtl/core/mipe_pkg.sv
// Shared constants, codes and types of the mono icon pixel expander.
// No dependencies; used by every module of the block but mipe_ram.
`default_nettype none

package mipe_pkg;

	localparam int COORD_BITS     = 10;
	localparam int POS_BITS       = COORD_BITS + 1;
	localparam int ICON_WORDS_DEF = 2048;
	localparam int WORD_BITS      = 32;
	localparam int BIT_SEL_BITS   = 5;
	localparam int INDEX_BITS     = 11;
	localparam int COLOR_BITS     = 16;
	localparam int MODE_BITS      = 2;
	localparam int KIND_BITS      = 2;
	localparam int CFG_INDEX_BITS = 3;
	// Linear bit index into the icon and the word number taken from it.
	localparam int PIX_IDX_BITS   = 2 * COORD_BITS + 2;
	localparam int WNUM_BITS      = PIX_IDX_BITS - BIT_SEL_BITS;

	localparam logic [KIND_BITS-1:0] KIND_LOAD  = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_START = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_STEP  = 2'd2;

	localparam logic [MODE_BITS-1:0] MODE_OFFSET = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_END    = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_CENTER = 2'd2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ICON_WIDTH  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ICON_HEIGHT = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AREA_LEFT   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AREA_TOP    = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AREA_RIGHT  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_AREA_BOTTOM = 3'd5;

	localparam logic [COORD_BITS-1:0] ICON_SIZE_RST = COORD_BITS'(1);
	localparam logic [COORD_BITS-1:0] AREA_MAX_RST  = {COORD_BITS{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_IDX,
		ST_MOD_Q,
		ST_MOD_R,
		ST_MOD_F,
		ST_WRITE,
		ST_READ,
		ST_EMIT,
		ST_PLACE1,
		ST_PLACE2
	} state_t;

	typedef struct packed {
		logic capture;
		logic idx_en;
		logic modq_en;
		logic mod_sel_load;
		logic modr_en;
		logic modf_en;
		logic ram_we;
		logic ram_re;
		logic place1;
		logic place2;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic active;
	} stat_t;

endpackage

`default_nettype wire

// File: rtl/core/mipe_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module mipe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                we,
	input  logic                re,
	input  logic [AddrBits-1:0] addr,
	input  logic [WIDTH-1:0]    wdata,
	output logic [WIDTH-1:0]    rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/mipe_datapath.sv
// Datapath of the icon pixel expander: configuration, placement, scan state,
// icon address reduction, icon memory and the result register. Uses mipe_pkg, mipe_ram.
`default_nettype none

module mipe_datapath #(
	parameter int ICON_WORDS = mipe_pkg::ICON_WORDS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mipe_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [mipe_pkg::COORD_BITS-1:0]      cfg_data,
	input  logic [mipe_pkg::INDEX_BITS-1:0]      word_index,
	input  logic [mipe_pkg::WORD_BITS-1:0]       word_data,
	input  logic [mipe_pkg::COORD_BITS-1:0]      place_x,
	input  logic [mipe_pkg::MODE_BITS-1:0]       place_x_mode,
	input  logic [mipe_pkg::COORD_BITS-1:0]      place_y,
	input  logic [mipe_pkg::MODE_BITS-1:0]       place_y_mode,
	input  logic [mipe_pkg::COLOR_BITS-1:0]      fore_color,
	input  logic [mipe_pkg::COLOR_BITS-1:0]      back_color,
	input  logic                                 back_enable,
	input  mipe_pkg::cmd_t                       cmd,
	output mipe_pkg::stat_t                      stat,
	output logic [mipe_pkg::POS_BITS-1:0]        pixel_x,
	output logic [mipe_pkg::POS_BITS-1:0]        pixel_y,
	output logic [mipe_pkg::COLOR_BITS-1:0]      pixel_color,
	output logic                                 pixel_write,
	output logic                                 last_pixel
);

	import mipe_pkg::*;

	localparam int AW        = (ICON_WORDS > 1) ? $clog2(ICON_WORDS) : 1;
	localparam int Shift     = WNUM_BITS;
	localparam int RecipBits = WNUM_BITS + 1;
	// Floor reciprocal: the estimated quotient is at most one below the true one.
	localparam logic [RecipBits-1:0] Recip = RecipBits'((2 ** Shift) / ICON_WORDS);
	localparam logic [WNUM_BITS-1:0] DepthW = WNUM_BITS'(ICON_WORDS);
	localparam logic [AW:0]          DepthR = (AW + 1)'(ICON_WORDS);

	function automatic logic [COORD_BITS-1:0] span_of(
		input logic [COORD_BITS-1:0] lo,
		input logic [COORD_BITS-1:0] hi
	);
		span_of = (hi >= lo) ? (hi - lo) : '0;
	endfunction

	function automatic logic [COORD_BITS-1:0] min_of(
		input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b
	);
		min_of = (a < b) ? a : b;
	endfunction

	function automatic logic [POS_BITS-1:0] origin_of(
		input logic [MODE_BITS-1:0]  mode,
		input logic [COORD_BITS-1:0] off,
		input logic [COORD_BITS-1:0] lo,
		input logic [COORD_BITS-1:0] hi,
		input logic [COORD_BITS-1:0] span,
		input logic [COORD_BITS-1:0] drawn
	);
		logic [COORD_BITS-1:0] slack;
		slack = span - drawn;
		case (mode)
			MODE_END:    origin_of = POS_BITS'(hi - drawn);
			MODE_CENTER: origin_of = POS_BITS'(slack >> 1) + POS_BITS'(lo);
			default:     origin_of = POS_BITS'(off) + POS_BITS'(lo);
		endcase
	endfunction

	function automatic logic [COORD_BITS-1:0] crop_of(
		input logic [MODE_BITS-1:0]  mode,
		input logic [COORD_BITS-1:0] size,
		input logic [COORD_BITS-1:0] drawn
	);
		logic [COORD_BITS-1:0] excess;
		excess = size - drawn;
		crop_of = (mode == MODE_CENTER) ? (excess >> 1) : '0;
	endfunction

	// Configuration registers.
	logic [COORD_BITS-1:0] icon_width_q, icon_height_q;
	logic [COORD_BITS-1:0] area_left_q, area_top_q, area_right_q, area_bottom_q;

	// Captured input item.
	logic [INDEX_BITS-1:0] cap_index_q;
	logic [WORD_BITS-1:0]  cap_data_q;
	logic [COORD_BITS-1:0] cap_px_q, cap_py_q;
	logic [MODE_BITS-1:0]  cap_pxm_q, cap_pym_q;
	logic [COLOR_BITS-1:0] cap_fore_q, cap_back_q;
	logic                  cap_ben_q;

	// Draw state.
	logic [POS_BITS-1:0]   origin_x_q, origin_y_q;
	logic [COORD_BITS-1:0] crop_x_q, crop_y_q;
	logic [COORD_BITS-1:0] drawn_width_q, drawn_height_q;
	logic [COORD_BITS-1:0] span_x_q, span_y_q;
	logic [COORD_BITS-1:0] scan_col_q, scan_row_q;
	logic [COLOR_BITS-1:0] saved_fore_q, saved_back_q;
	logic                  saved_back_enable_q;
	logic                  drawing_active_q;

	// Address path.
	logic [POS_BITS-1:0]              row_sum, col_sum;
	logic [2*COORD_BITS:0]            row_prod;
	logic [PIX_IDX_BITS-1:0]          idx_d, idx_q;
	logic [WNUM_BITS-1:0]             wnum, wnum_q, quot_q;
	logic [WNUM_BITS+RecipBits-1:0]   quot_prod;
	logic [2*WNUM_BITS-1:0]           back_prod;
	logic [WNUM_BITS-1:0]             rem_full;
	logic [AW:0]                      rem_q;
	logic [AW-1:0]                    addr_q;
	logic [WORD_BITS-1:0]             rd_data;

	// Pixel decision.
	logic [POS_BITS-1:0]   col_next, row_next;
	logic                  col_end, row_end, bit_set;
	logic [POS_BITS-1:0]   px_d, py_d;
	logic [COLOR_BITS-1:0] color_d;
	logic                  write_d, last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icon_width_q  <= ICON_SIZE_RST;
			icon_height_q <= ICON_SIZE_RST;
			area_left_q   <= '0;
			area_top_q    <= '0;
			area_right_q  <= AREA_MAX_RST;
			area_bottom_q <= AREA_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ICON_WIDTH:  icon_width_q  <= cfg_data;
				REG_ICON_HEIGHT: icon_height_q <= cfg_data;
				REG_AREA_LEFT:   area_left_q   <= cfg_data;
				REG_AREA_TOP:    area_top_q    <= cfg_data;
				REG_AREA_RIGHT:  area_right_q  <= cfg_data;
				REG_AREA_BOTTOM: area_bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cap_index_q <= word_index;
			cap_data_q  <= word_data;
			cap_px_q    <= place_x;
			cap_pxm_q   <= place_x_mode;
			cap_py_q    <= place_y;
			cap_pym_q   <= place_y_mode;
			cap_fore_q  <= fore_color;
			cap_back_q  <= back_color;
			cap_ben_q   <= back_enable;
		end
	end

	// Bit index of the current pixel: width * (row + crop_y) + (col + crop_x).
	assign row_sum  = POS_BITS'(scan_row_q) + POS_BITS'(crop_y_q);
	assign col_sum  = POS_BITS'(scan_col_q) + POS_BITS'(crop_x_q);
	assign row_prod = icon_width_q * row_sum;
	assign idx_d    = PIX_IDX_BITS'(row_prod) + PIX_IDX_BITS'(col_sum);

	// Word number modulo the memory depth, by reciprocal and one correction.
	assign wnum      = cmd.mod_sel_load ? WNUM_BITS'(cap_index_q)
	                                    : idx_q[PIX_IDX_BITS-1:BIT_SEL_BITS];
	assign quot_prod = wnum * Recip;
	assign back_prod = quot_q * DepthW;
	assign rem_full  = wnum_q - back_prod[WNUM_BITS-1:0];

	always_ff @(posedge clk) begin
		if (cmd.idx_en) begin
			idx_q <= idx_d;
		end
		if (cmd.modq_en) begin
			wnum_q <= wnum;
			quot_q <= quot_prod[Shift +: WNUM_BITS];
		end
		if (cmd.modr_en) begin
			rem_q <= rem_full[AW:0];
		end
		if (cmd.modf_en) begin
			addr_q <= (rem_q >= DepthR) ? AW'(rem_q - DepthR) : rem_q[AW-1:0];
		end
	end

	mipe_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(ICON_WORDS)
	) u_icon_ram (
		.clk   (clk),
		.we    (cmd.ram_we),
		.re    (cmd.ram_re),
		.addr  (addr_q),
		.wdata (cap_data_q),
		.rdata (rd_data)
	);

	assign col_next = POS_BITS'(scan_col_q) + POS_BITS'(1);
	assign row_next = POS_BITS'(scan_row_q) + POS_BITS'(1);
	assign col_end  = col_next >= POS_BITS'(drawn_width_q);
	assign row_end  = row_next >= POS_BITS'(drawn_height_q);
	assign bit_set  = rd_data[idx_q[BIT_SEL_BITS-1:0]];

	always_comb begin
		px_d    = '0;
		py_d    = '0;
		color_d = '0;
		write_d = 1'b0;
		last_d  = 1'b1;
		if (drawing_active_q) begin
			px_d   = origin_x_q + POS_BITS'(scan_col_q);
			py_d   = origin_y_q + POS_BITS'(scan_row_q);
			last_d = col_end && row_end;
			if (bit_set) begin
				color_d = saved_fore_q;
				write_d = 1'b1;
			end else if (saved_back_enable_q) begin
				color_d = saved_back_q;
				write_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q          <= '0;
			origin_y_q          <= '0;
			crop_x_q            <= '0;
			crop_y_q            <= '0;
			drawn_width_q       <= '0;
			drawn_height_q      <= '0;
			span_x_q            <= '0;
			span_y_q            <= '0;
			scan_col_q          <= '0;
			scan_row_q          <= '0;
			saved_fore_q        <= '0;
			saved_back_q        <= '0;
			saved_back_enable_q <= 1'b0;
			drawing_active_q    <= 1'b0;
		end else if (cmd.place1) begin
			span_x_q            <= span_of(area_left_q, area_right_q);
			span_y_q            <= span_of(area_top_q, area_bottom_q);
			drawn_width_q       <= min_of(icon_width_q, span_of(area_left_q, area_right_q));
			drawn_height_q      <= min_of(icon_height_q, span_of(area_top_q, area_bottom_q));
			saved_fore_q        <= cap_fore_q;
			saved_back_q        <= cap_back_q;
			saved_back_enable_q <= cap_ben_q;
			scan_col_q          <= '0;
			scan_row_q          <= '0;
		end else if (cmd.place2) begin
			origin_x_q <= origin_of(cap_pxm_q, cap_px_q, area_left_q, area_right_q,
				span_x_q, drawn_width_q);
			origin_y_q <= origin_of(cap_pym_q, cap_py_q, area_top_q, area_bottom_q,
				span_y_q, drawn_height_q);
			crop_x_q   <= crop_of(cap_pxm_q, icon_width_q, drawn_width_q);
			crop_y_q   <= crop_of(cap_pym_q, icon_height_q, drawn_height_q);
			drawing_active_q <= (drawn_width_q != '0) && (drawn_height_q != '0);
		end else if (cmd.emit && drawing_active_q) begin
			if (last_d) begin
				drawing_active_q <= 1'b0;
				scan_col_q       <= '0;
				scan_row_q       <= '0;
			end else if (col_end) begin
				scan_col_q <= '0;
				scan_row_q <= row_next[COORD_BITS-1:0];
			end else begin
				scan_col_q <= col_next[COORD_BITS-1:0];
			end
		end
	end

	// Result register; it holds while the downstream side stalls.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pixel_x     <= px_d;
			pixel_y     <= py_d;
			pixel_color <= color_d;
			pixel_write <= write_d;
			last_pixel  <= last_d;
		end
	end

	assign stat.active = drawing_active_q;

endmodule

`default_nettype wire

// File: rtl/core/mipe_ctrl.sv
// Controller of the icon pixel expander: sequences load, start and step items
// and owns the channel handshakes. Uses mipe_pkg.
`default_nettype none

module mipe_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [mipe_pkg::KIND_BITS-1:0] kind,
	output logic                           out_valid,
	input  logic                           out_stall,
	input  mipe_pkg::stat_t                stat,
	output mipe_pkg::cmd_t                 cmd
);

	import mipe_pkg::*;

	state_t state_q, state_d;
	logic   load_q;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free = !out_valid_q || !out_stall;
	assign accept   = (state_q == ST_IDLE) && in_valid;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (kind)
						KIND_LOAD:  state_d = ST_MOD_Q;
						KIND_START: state_d = ST_PLACE1;
						KIND_STEP:  state_d = stat.active ? ST_IDX : ST_EMIT;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_IDX:    state_d = ST_MOD_Q;
			ST_MOD_Q:  state_d = ST_MOD_R;
			ST_MOD_R:  state_d = ST_MOD_F;
			ST_MOD_F:  state_d = load_q ? ST_WRITE : ST_READ;
			ST_WRITE:  state_d = ST_IDLE;
			ST_READ:   state_d = ST_EMIT;
			ST_EMIT:   state_d = out_free ? ST_IDLE : ST_EMIT;
			ST_PLACE1: state_d = ST_PLACE2;
			ST_PLACE2: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd              = '0;
		cmd.capture      = accept;
		cmd.mod_sel_load = load_q;
		case (state_q)
			ST_IDX:    cmd.idx_en  = 1'b1;
			ST_MOD_Q:  cmd.modq_en = 1'b1;
			ST_MOD_R:  cmd.modr_en = 1'b1;
			ST_MOD_F:  cmd.modf_en = 1'b1;
			ST_WRITE:  cmd.ram_we  = 1'b1;
			ST_READ:   cmd.ram_re  = 1'b1;
			ST_EMIT:   cmd.emit    = out_free;
			ST_PLACE1: cmd.place1  = 1'b1;
			ST_PLACE2: cmd.place2  = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			load_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				load_q <= (kind == KIND_LOAD);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/core/mono_icon_pixel_expander.sv
// Top level of the mono icon pixel expander: controller plus datapath.
// Uses mipe_pkg, mipe_ctrl, mipe_datapath (which holds the icon RAM).
//
//   channel  | handshake             | carries
//   ---------+-----------------------+------------------------------------------
//   cfg      | cfg_we                | cfg_index, cfg_data (10-bit registers)
//   in       | in_valid / in_stall   | kind, word_index, word_data, placement, colors
//   out      | out_valid / out_stall | pixel_x, pixel_y, pixel_color, pixel_write,
//            |                       | last_pixel
//
// A step during a draw runs the index multiply, the quotient, remainder and correction steps
// of the reduction modulo the icon memory depth, the registered RAM read and the result.
// A load runs the same reduction, then the RAM write; a start finds the clip, then origin and
// crop; a step with no draw active goes straight to the result. One item is in work at a time.
// Reset clears control and draw state; the icon memory is not cleared.
// A stalled result holds in the output register; a finished step waits for it.
`default_nettype none

module mono_icon_pixel_expander #(
	parameter int ICON_WORDS = mipe_pkg::ICON_WORDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mipe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [mipe_pkg::COORD_BITS-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [mipe_pkg::KIND_BITS-1:0]      kind,
	input  logic [mipe_pkg::INDEX_BITS-1:0]     word_index,
	input  logic [mipe_pkg::WORD_BITS-1:0]      word_data,
	input  logic [mipe_pkg::COORD_BITS-1:0]     place_x,
	input  logic [mipe_pkg::MODE_BITS-1:0]      place_x_mode,
	input  logic [mipe_pkg::COORD_BITS-1:0]     place_y,
	input  logic [mipe_pkg::MODE_BITS-1:0]      place_y_mode,
	input  logic [mipe_pkg::COLOR_BITS-1:0]     fore_color,
	input  logic [mipe_pkg::COLOR_BITS-1:0]     back_color,
	input  logic                                back_enable,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mipe_pkg::POS_BITS-1:0]       pixel_x,
	output logic [mipe_pkg::POS_BITS-1:0]       pixel_y,
	output logic [mipe_pkg::COLOR_BITS-1:0]     pixel_color,
	output logic                                pixel_write,
	output logic                                last_pixel
);

	import mipe_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	mipe_datapath #(
		.ICON_WORDS(ICON_WORDS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.word_index   (word_index),
		.word_data    (word_data),
		.place_x      (place_x),
		.place_x_mode (place_x_mode),
		.place_y      (place_y),
		.place_y_mode (place_y_mode),
		.fore_color   (fore_color),
		.back_color   (back_color),
		.back_enable  (back_enable),
		.cmd          (cmd),
		.stat         (stat),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_color  (pixel_color),
		.pixel_write  (pixel_write),
		.last_pixel   (last_pixel)
	);

endmodule

`default_nettype wire

// File: rtl/core/mipe_checker.sv
// Port-level checks of the mono icon pixel expander and their bind.
// Uses mipe_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mipe_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic [mipe_pkg::KIND_BITS-1:0] kind,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [mipe_pkg::COLOR_BITS-1:0] pixel_color,
	input logic                           pixel_write
);

	import mipe_pkg::*;

	// A stalled result stays offered.
	`MIPE_ASSERT_NEXT(a_result_held, clk, arst_n, out_valid && out_stall, out_valid)

	// A step transfer always keeps the input stalled in the cycle after it.
	`MIPE_ASSERT_NEXT(a_step_busy, clk, arst_n, in_valid && !in_stall && kind == KIND_STEP, in_stall)

	// Pixels that are not written carry no color.
	`MIPE_ASSERT_IMPL(a_unwritten_black, clk, arst_n, out_valid && !pixel_write, pixel_color == '0)

	// A new result only appears while an item was in work.
	`MIPE_ASSERT_IMPL(a_result_from_work, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule

bind mono_icon_pixel_expander mipe_checker u_mipe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.kind        (kind),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pixel_color (pixel_color),
	.pixel_write (pixel_write)
);

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the mono icon pixel expander: drives register writes and load, start,
// step and spare transfers, predicts every pixel result in a behavioral model and compares it whole.
// Depends on mipe_pkg and the mono_icon_pixel_expander RTL; reads and writes no files.
module testbench;
	import mipe_pkg::*;

	localparam int          MEM_WORDS   = ICON_WORDS_DEF;
	localparam int          QUIET_LIMIT = 5000;
	localparam int          SETTLE      = 12;
	localparam int          HOLD_CYCLES = 400;
	localparam int          MAX_REPORTS = 10;
	localparam int unsigned CMASK       = (1 << COORD_BITS) - 1;
	localparam int unsigned PMASK       = (1 << POS_BITS) - 1;

	localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;
	localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

	typedef struct {
		logic [KIND_BITS-1:0]  kind;
		logic [INDEX_BITS-1:0] widx;
		logic [WORD_BITS-1:0]  wdata;
		logic [COORD_BITS-1:0] px;
		logic [MODE_BITS-1:0]  pxm;
		logic [COORD_BITS-1:0] py;
		logic [MODE_BITS-1:0]  pym;
		logic [COLOR_BITS-1:0] fg;
		logic [COLOR_BITS-1:0] bg;
		logic                  ben;
	} icon_req_t;

	typedef struct packed {
		logic [POS_BITS-1:0]   x;
		logic [POS_BITS-1:0]   y;
		logic [COLOR_BITS-1:0] color;
		logic                  wr;
		logic                  last;
	} pixel_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [COORD_BITS-1:0]     cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic [KIND_BITS-1:0]      kind;
	logic [INDEX_BITS-1:0]     word_index;
	logic [WORD_BITS-1:0]      word_data;
	logic [COORD_BITS-1:0]     place_x;
	logic [MODE_BITS-1:0]      place_x_mode;
	logic [COORD_BITS-1:0]     place_y;
	logic [MODE_BITS-1:0]      place_y_mode;
	logic [COLOR_BITS-1:0]     fore_color;
	logic [COLOR_BITS-1:0]     back_color;
	logic                      back_enable;
	logic                      out_valid;
	logic                      out_stall;
	logic [POS_BITS-1:0]       pixel_x;
	logic [POS_BITS-1:0]       pixel_y;
	logic [COLOR_BITS-1:0]     pixel_color;
	logic                      pixel_write;
	logic                      last_pixel;

	// Behavioral copy of the icon memory, registers and draw state.
	logic [WORD_BITS-1:0]  pic_mem [MEM_WORDS];
	bit                    pic_known [MEM_WORDS];
	int unsigned           reg_icon_w, reg_icon_h, reg_left, reg_top, reg_right, reg_bottom;
	int unsigned           org_x, org_y, skip_x, skip_y, vis_w, vis_h, col_pos, row_pos;
	logic [COLOR_BITS-1:0] fg_color, back_tint;
	bit                    bg_on, draw_on;
	pixel_t                pixel_queue [$];

	int unsigned items_sent, loads_sent, starts_sent, steps_sent;
	int unsigned results_seen, writes_seen, errors, quiet_cycles;
	int unsigned send_idle_pct, recv_stall_pct, hold_req;

	mono_icon_pixel_expander u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .word_index(word_index), .word_data(word_data),
		.place_x(place_x), .place_x_mode(place_x_mode),
		.place_y(place_y), .place_y_mode(place_y_mode),
		.fore_color(fore_color), .back_color(back_color), .back_enable(back_enable),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_color(pixel_color),
		.pixel_write(pixel_write), .last_pixel(last_pixel)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------- model

	// Clips one axis to the area and works out the screen origin and the icon crop.
	function automatic void fit_axis(input int unsigned size, lo, hi, off, mode,
			output int unsigned vis, org, skip);
		int unsigned span;
		span = (hi >= lo) ? hi - lo : 0;
		vis  = (size < span) ? size : span;
		skip = 0;
		if (mode == MODE_END) begin
			org = hi - vis;
		end else if (mode == MODE_CENTER) begin
			org  = (span - vis) / 2 + lo;
			skip = (size - vis) / 2;
		end else begin
			org = off + lo;
		end
		org  &= PMASK;
		skip &= CMASK;
	endfunction

	// Word of icon memory that the next pixel of the current draw reads.
	function automatic int unsigned step_word();
		return ((reg_icon_w * (row_pos + skip_y) + col_pos + skip_x) / WORD_BITS) % MEM_WORDS;
	endfunction

	function automatic void model_accept(input icon_req_t r);
		int unsigned bitpos;
		logic [WORD_BITS-1:0] w;
		pixel_t p;
		case (r.kind)
			KIND_LOAD: begin
				pic_mem[r.widx % MEM_WORDS]   = r.wdata;
				pic_known[r.widx % MEM_WORDS] = 1'b1;
			end
			KIND_START: begin
				fit_axis(reg_icon_w, reg_left, reg_right, r.px, r.pxm, vis_w, org_x, skip_x);
				fit_axis(reg_icon_h, reg_top, reg_bottom, r.py, r.pym, vis_h, org_y, skip_y);
				fg_color  = r.fg;
				back_tint = r.bg;
				bg_on     = r.ben;
				col_pos   = 0;
				row_pos   = 0;
				draw_on   = vis_w != 0 && vis_h != 0;
			end
			KIND_STEP: begin
				p = '0;
				if (!draw_on) begin
					p.last = 1'b1;
				end else begin
					bitpos = reg_icon_w * (row_pos + skip_y) + col_pos + skip_x;
					w = pic_mem[(bitpos / WORD_BITS) % MEM_WORDS];
					if (w[bitpos % WORD_BITS]) begin
						p.color = fg_color;
						p.wr    = 1'b1;
					end else if (bg_on) begin
						p.color = back_tint;
						p.wr    = 1'b1;
					end
					p.last = (col_pos + 1 >= vis_w) && (row_pos + 1 >= vis_h);
					p.x    = POS_BITS'((org_x + col_pos) & PMASK);
					p.y    = POS_BITS'((org_y + row_pos) & PMASK);
					if (p.last) begin
						draw_on = 1'b0;
						col_pos = 0;
						row_pos = 0;
					end else if (col_pos + 1 >= vis_w) begin
						col_pos = 0;
						row_pos = (row_pos + 1) & CMASK;
					end else begin
						col_pos = (col_pos + 1) & CMASK;
					end
				end
				pixel_queue.push_back(p);
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- drivers

	function automatic icon_req_t make_req(input logic [KIND_BITS-1:0] k);
		icon_req_t r;
		r.kind  = k;
		r.widx  = INDEX_BITS'($urandom);
		r.wdata = $urandom;
		r.px    = COORD_BITS'($urandom);
		r.pxm   = MODE_BITS'($urandom);
		r.py    = COORD_BITS'($urandom);
		r.pym   = MODE_BITS'($urandom);
		r.fg    = COLOR_BITS'($urandom);
		r.bg    = COLOR_BITS'($urandom);
		r.ben   = 1'($urandom);
		return r;
	endfunction

	function automatic logic [WORD_BITS-1:0] random_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Presents one item and returns at the edge where the transfer happens.
	task automatic send_item(input icon_req_t r);
		int gap = 0;
		while (send_idle_pct != 0 && gap < 80 && $urandom_range(99) < send_idle_pct)
			gap++;
		@(negedge clk);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		kind         <= r.kind;
		word_index   <= r.widx;
		word_data    <= r.wdata;
		place_x      <= r.px;
		place_x_mode <= r.pxm;
		place_y      <= r.py;
		place_y_mode <= r.pym;
		fore_color   <= r.fg;
		back_color   <= r.bg;
		back_enable  <= r.ben;
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_stall);
		model_accept(r);
		case (r.kind)
			KIND_LOAD:  loads_sent++;
			KIND_START: starts_sent++;
			KIND_STEP:  steps_sent++;
			default: ;
		endcase
		if (r.kind != KIND_SPARE)
			items_sent++;
	endtask

	task automatic send_load(input logic [INDEX_BITS-1:0] idx, input logic [WORD_BITS-1:0] data);
		icon_req_t r;
		r = make_req(KIND_LOAD);
		r.widx  = idx;
		r.wdata = data;
		send_item(r);
	endtask

	task automatic send_start(input logic [COORD_BITS-1:0] px, input logic [MODE_BITS-1:0] pxm,
			input logic [COORD_BITS-1:0] py, input logic [MODE_BITS-1:0] pym,
			input logic [COLOR_BITS-1:0] fg, input logic [COLOR_BITS-1:0] bg, input logic ben);
		icon_req_t r;
		r = make_req(KIND_START);
		r.px  = px;
		r.pxm = pxm;
		r.py  = py;
		r.pym = pym;
		r.fg  = fg;
		r.bg  = bg;
		r.ben = ben;
		send_item(r);
	endtask

	// A pixel step; the icon word it reads is loaded first if it was never written.
	task automatic send_step();
		int unsigned w;
		if (draw_on) begin
			w = step_word();
			if (!pic_known[w])
				send_load(INDEX_BITS'(w), random_word());
		end
		send_item(make_req(KIND_STEP));
	endtask

	task automatic send_noise();
		send_item(make_req(KIND_SPARE));
	endtask

	// Lowers valid, lets every expected pixel come out, then lets a trailing load finish.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pixel_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= COORD_BITS'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ICON_WIDTH:  reg_icon_w = value & CMASK;
			REG_ICON_HEIGHT: reg_icon_h = value & CMASK;
			REG_AREA_LEFT:   reg_left   = value & CMASK;
			REG_AREA_TOP:    reg_top    = value & CMASK;
			REG_AREA_RIGHT:  reg_right  = value & CMASK;
			REG_AREA_BOTTOM: reg_bottom = value & CMASK;
			default: ;
		endcase
	endtask

	task automatic set_geometry(input int unsigned w, h, l, t, r, b);
		wait_idle();
		write_reg(REG_ICON_WIDTH, w);
		write_reg(REG_ICON_HEIGHT, h);
		write_reg(REG_AREA_LEFT, l);
		write_reg(REG_AREA_TOP, t);
		write_reg(REG_AREA_RIGHT, r);
		write_reg(REG_AREA_BOTTOM, b);
	endtask

	// ---------------------------------------------------------------- receiver and checks

	// Random output stalls, or one long hold-off when a test asks for it.
	initial begin : recv_side
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct;
			end
		end
	end

	always @(posedge clk) begin : check_pixels
		pixel_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {pixel_x, pixel_y, pixel_color, pixel_write, last_pixel};
			results_seen++;
			if (pixel_write)
				writes_seen++;
			if (pixel_queue.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: pixel with none expected: x=%0d y=%0d color=%h write=%b last=%b",
						$realtime, got.x, got.y, got.color, got.wr, got.last);
			end else begin
				want = pixel_queue.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("%0t: pixel mismatch, expected x=%0d y=%0d color=%h write=%b last=%b",
							$realtime, want.x, want.y, want.color, want.wr, want.last);
						$display("%0t:                 actual x=%0d y=%0d color=%h write=%b last=%b",
							$realtime, got.x, got.y, got.color, got.wr, got.last);
					end
				end
			end
		end
	end

	// Ends the run if no transfer happens on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles, %0d pixels still expected",
				QUIET_LIMIT, pixel_queue.size());
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- tests

	task automatic test_idle_step();
		send_step();
	endtask

	// Centered crop, bottom alignment, spare modes, restart, transparency and an ignored kind.
	task automatic test_placement_modes();
		set_geometry(5, 2, 100, 200, 103, CMASK);
		send_load(11'd0, 32'h0000_00AA);
		send_load(11'd1024, 32'h0000_0000);
		send_load(11'd2047, 32'hFFFF_FFFF);
		send_start(10'd0, MODE_CENTER, 10'd0, MODE_END, 16'hFFFF, 16'h0000, 1'b1);
		// Six pixels, then one step after the draw has finished.
		repeat (7) send_step();
		send_start(10'h3FF, MODE_SPARE, 10'h3FF, MODE_SPARE, 16'h0000, 16'hFFFF, 1'b0);
		repeat (2) send_step();
		send_start(10'd1, MODE_OFFSET, 10'd0, MODE_OFFSET, 16'h1234, 16'hFFFF, 1'b1);
		send_step();
		send_noise();
	endtask

	// Areas with the right edge left of the left edge, and with zero height, draw nothing.
	task automatic test_empty_area();
		set_geometry(4, 4, 9, 0, 5, CMASK);
		send_start(10'd0, MODE_OFFSET, 10'd0, MODE_OFFSET, 16'hAAAA, 16'h5555, 1'b1);
		send_step();
		set_geometry(4, 4, 0, 300, CMASK, 300);
		send_start(10'd0, MODE_CENTER, 10'd0, MODE_CENTER, 16'hAAAA, 16'h5555, 1'b1);
		send_step();
	endtask

	// The row pitch follows the icon width register even in the middle of a draw.
	task automatic test_pitch_change();
		set_geometry(4, 3, 0, 0, CMASK, CMASK);
		send_start(10'd20, MODE_OFFSET, 10'd30, MODE_OFFSET, 16'h0F0F, 16'hF0F0, 1'b1);
		repeat (3) send_step();
		wait_idle();
		write_reg(REG_ICON_WIDTH, 7);
		repeat (3) send_step();
	endtask

	// The receiver holds off while steps keep coming, so the block has to stall its input.
	task automatic test_output_backpressure();
		set_geometry(8, 8, 0, 0, CMASK, CMASK);
		send_start(10'd3, MODE_OFFSET, 10'd5, MODE_OFFSET, 16'hC3C3, 16'h3C3C, 1'b0);
		hold_req = HOLD_CYCLES;
		repeat (24) send_step();
	endtask

	function automatic int unsigned pick_size(input int unsigned typical);
		case ($urandom_range(9))
			0: return 1;
			1: return CMASK;
			2: return $urandom_range(1, CMASK);
			default: return $urandom_range(1, typical);
		endcase
	endfunction

	function automatic void pick_span(output int unsigned lo, hi);
		case ($urandom_range(9))
			0: begin lo = 0; hi = CMASK; end
			1: begin lo = CMASK; hi = 0; end
			2: begin lo = $urandom_range(CMASK); hi = $urandom_range(CMASK); end
			3: begin lo = $urandom_range(CMASK); hi = lo; end
			default: begin lo = $urandom_range(0, 1000); hi = lo + $urandom_range(1, 23); end
		endcase
	endfunction

	// One draw: maybe new geometry, a start, then steps with a few loads and ignored items.
	task automatic draw_burst();
		int unsigned l, t, r, b, pixels, n;
		if ($urandom_range(3) == 0) begin
			if ($urandom_range(3) == 0) begin
				wait_idle();
				write_reg(REG_ICON_WIDTH, pick_size(24));
			end else begin
				pick_span(l, r);
				pick_span(t, b);
				set_geometry(pick_size(24), pick_size(16), l, t, r, b);
			end
		end
		send_start(($urandom_range(9) == 0) ? COORD_BITS'($urandom) : COORD_BITS'($urandom_range(40)),
			MODE_BITS'($urandom_range(3)),
			($urandom_range(9) == 0) ? COORD_BITS'($urandom) : COORD_BITS'($urandom_range(40)),
			MODE_BITS'($urandom_range(3)),
			COLOR_BITS'($urandom), COLOR_BITS'($urandom), 1'($urandom));
		pixels = draw_on ? vis_w * vis_h : 0;
		if (pixels <= 48 && $urandom_range(4) != 0)
			n = pixels + $urandom_range(0, 2);
		else
			n = $urandom_range(1, 30);
		repeat (n) begin
			case ($urandom_range(19))
				0: send_load(INDEX_BITS'($urandom), random_word());
				1: send_noise();
				default: send_step();
			endcase
		end
	endtask

	task automatic test_random_traffic();
		int unsigned stop_at;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			stop_at = items_sent + 370;
			while (items_sent < stop_at)
				draw_burst();
		end
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		kind         = '0;
		word_index   = '0;
		word_data    = '0;
		place_x      = '0;
		place_x_mode = '0;
		place_y      = '0;
		place_y_mode = '0;
		fore_color   = '0;
		back_color   = '0;
		back_enable  = 1'b0;
		out_stall    = 1'b0;
		hold_req     = 0;
		quiet_cycles = 0;
		reg_icon_w   = ICON_SIZE_RST;
		reg_icon_h   = ICON_SIZE_RST;
		reg_left     = 0;
		reg_top      = 0;
		reg_right    = AREA_MAX_RST;
		reg_bottom   = AREA_MAX_RST;
		draw_on      = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_idle_step();
		test_placement_modes();
		test_empty_area();
		test_pitch_change();
		test_output_backpressure();
		test_random_traffic();
		wait_idle();

		$display("Covered %0d items (%0d loads, %0d starts, %0d steps) and %0d pixel results, %0d written.",
			items_sent, loads_sent, starts_sent, steps_sent, results_seen, writes_seen);
		$display("Idling phases: none, sender 85/100, receiver 85/100, both 16/100; %0d errors.",
			errors);
		if (errors == 0 && pixel_queue.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
